### hdl/ptld_pkg.sv
// Shared types and constants for the point-to-line distance block.
// No dependencies; used by ptld_divsqrt and point_to_line_distance.
package ptld_pkg;

   localparam int MAX_DIMS_DEF = 16;

   localparam int COORD_W = 24;
   localparam int DIFF_W  = 25;
   localparam int MUL_W   = 27;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int VD_W    = 54;
   localparam int SQ_W    = 53;
   localparam int NUM_W   = 108;
   localparam int QNUM_W  = 106;
   localparam int DIST_W  = 27;

   localparam int DIV_STEPS  = 53;
   localparam int SQRT_STEPS = 27;
   localparam int STEP_W     = 6;
   localparam int PP_COUNT   = 8;
   localparam int PP_IDX_W   = 3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_VD,
      ST_MUL_DD,
      ST_MUL_VV,
      ST_ACC_VV,
      ST_CHECK,
      ST_NUM_MUL,
      ST_NUM_ACC,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PP_NONE,
      PP_VD_POS,
      PP_VD_NEG,
      PP_DD,
      PP_VV,
      PP_NUM_ADD,
      PP_NUM_SUB
   } pp_op_type;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_DIV,
      DS_SQRT,
      DS_DONE
   } ds_state_type;

endpackage

### hdl/ptld_divsqrt.sv
// Iterative restoring divide followed by integer square root, one bit per cycle.
// Both phases share a single 54-bit compare/subtract. Depends on ptld_pkg.
module ptld_divsqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ptld_pkg::QNUM_W-1:0]      num,
   input  logic [ptld_pkg::SQ_W-1:0]        den,
   output logic                             done,
   output logic [ptld_pkg::DIST_W-1:0]      root
);

   ptld_pkg::ds_state_type state_ff, state_in;

   logic [ptld_pkg::STEP_W-1:0] cnt_ff;
   logic [ptld_pkg::SQ_W-1:0]   rem_ff;
   logic [ptld_pkg::SQ_W-1:0]   num_sh_ff;
   logic [ptld_pkg::SQ_W:0]     q_ff;
   logic [ptld_pkg::DIST_W-1:0] root_ff;

   logic [ptld_pkg::SQ_W:0]     sub_a;
   logic [ptld_pkg::SQ_W:0]     sub_b;
   logic [ptld_pkg::SQ_W+1:0]   diff;
   logic                        ge;
   logic                        div_last;
   logic                        sqrt_last;

   assign diff      = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge        = ~diff[ptld_pkg::SQ_W+1];
   assign div_last  = (cnt_ff == ptld_pkg::STEP_W'(ptld_pkg::DIV_STEPS - 1));
   assign sqrt_last = (cnt_ff == ptld_pkg::STEP_W'(ptld_pkg::SQRT_STEPS - 1));
   assign root      = root_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptld_pkg::DS_IDLE: begin
            if (start) state_in = ptld_pkg::DS_DIV;
         end
         ptld_pkg::DS_DIV: begin
            if (div_last) state_in = ptld_pkg::DS_SQRT;
         end
         ptld_pkg::DS_SQRT: begin
            if (sqrt_last) state_in = ptld_pkg::DS_DONE;
         end
         ptld_pkg::DS_DONE: begin
            state_in = ptld_pkg::DS_IDLE;
         end
         default: state_in = ptld_pkg::DS_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == ptld_pkg::DS_DONE);
      if (state_ff == ptld_pkg::DS_DIV) begin
         sub_a = {rem_ff, num_sh_ff[ptld_pkg::SQ_W-1]};
         sub_b = {1'b0, den};
      end else begin
         sub_a = {rem_ff[ptld_pkg::SQ_W-2:0], q_ff[ptld_pkg::SQ_W:ptld_pkg::SQ_W-1]};
         sub_b = {{(ptld_pkg::SQ_W - 1 - ptld_pkg::DIST_W){1'b0}}, root_ff, 2'b01};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptld_pkg::DS_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ptld_pkg::DS_IDLE: cnt_ff <= '0;
            ptld_pkg::DS_DIV:  cnt_ff <= div_last ? '0 : cnt_ff + 1'b1;
            ptld_pkg::DS_SQRT: cnt_ff <= cnt_ff + 1'b1;
            default:           cnt_ff <= '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ptld_pkg::DS_IDLE: begin
            if (start) begin
               rem_ff    <= num[ptld_pkg::QNUM_W-1:ptld_pkg::SQ_W];
               num_sh_ff <= num[ptld_pkg::SQ_W-1:0];
               q_ff      <= '0;
            end
         end
         ptld_pkg::DS_DIV: begin
            num_sh_ff <= {num_sh_ff[ptld_pkg::SQ_W-2:0], 1'b0};
            q_ff      <= {q_ff[ptld_pkg::SQ_W-1:0], ge};
            if (div_last) begin
               rem_ff  <= '0;
               root_ff <= '0;
            end else begin
               rem_ff <= ge ? diff[ptld_pkg::SQ_W-1:0] : sub_a[ptld_pkg::SQ_W-1:0];
            end
         end
         ptld_pkg::DS_SQRT: begin
            rem_ff  <= ge ? diff[ptld_pkg::SQ_W-1:0] : sub_a[ptld_pkg::SQ_W-1:0];
            q_ff    <= {q_ff[ptld_pkg::SQ_W-2:0], 2'b00};
            root_ff <= {root_ff[ptld_pkg::DIST_W-2:0], ge};
         end
         default: begin
         end
      endcase
   end

endmodule

### hdl/point_to_line_distance.sv
// Point-to-line distance in N dimensions, one coordinate per transaction.
// Depends on ptld_pkg and ptld_divsqrt.
//
// Usage: each request transaction carries one coordinate of the point p and of
// the line ends a and b (signed Q11.12). The block accumulates v.d, d.d and
// v.v with one shared 27x27 multiplier. A transaction with last_coord set
// produces one response: floor(sqrt(vv - vd*vd/dd)) in unsigned Q.12, or 0
// with degenerate_line set when a equals b. Coordinates past MAX_DIMS are
// dropped and flagged with too_many_coords on the response.
// Sequence: each coordinate passes the v.d, d.d and v.v multiply states and the
// v.v accumulate; a last one goes on to a check, 8 partial products for
// vv*dd - vd*vd, their accumulate, a divide/root start, 53 divide and 27
// square-root steps and the output state; a degenerate line goes from the check
// to the output state. These steps are set by the one multiplier and the one
// bit-per-cycle divide/root unit. req_stall is high while busy.
// The response sits in an output register; a stalled response holds and the
// next request is taken meanwhile, but a new response waits for the slot.
// Reset (synchronous, active high) clears sums, count and the response valid.
module point_to_line_distance #(
   parameter int MAX_DIMS = ptld_pkg::MAX_DIMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ptld_pkg::COORD_W-1:0] req_point_coord,
   input  logic signed [ptld_pkg::COORD_W-1:0] req_line_start_coord,
   input  logic signed [ptld_pkg::COORD_W-1:0] req_line_end_coord,
   input  logic                                req_last_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ptld_pkg::DIST_W-1:0]         rsp_distance,
   output logic                                rsp_degenerate_line,
   output logic                                rsp_too_many_coords
);

   localparam int CNT_W = $clog2(MAX_DIMS + 1);

   ptld_pkg::state_type state_ff, state_in;

   // accepted coordinate
   logic [ptld_pkg::DIFF_W-1:0]   v_mag_ff;
   logic [ptld_pkg::DIFF_W-1:0]   d_mag_ff;
   logic                          vd_neg_ff;
   logic                          last_ff;
   logic                          take_ff;

   // running sums
   logic [ptld_pkg::VD_W-1:0]     vd_ff;
   logic [ptld_pkg::SQ_W-1:0]     dd_ff;
   logic [ptld_pkg::SQ_W-1:0]     vv_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          ovf_ff;

   // shared multiplier
   logic [ptld_pkg::MUL_W-1:0]    mul_a;
   logic [ptld_pkg::MUL_W-1:0]    mul_b;
   logic [ptld_pkg::PROD_W-1:0]   prod_in;
   logic [ptld_pkg::PROD_W-1:0]   prod_ff;
   ptld_pkg::pp_op_type           pp_op_in, pp_op_ff;
   logic [1:0]                    pp_shift_in, pp_shift_ff;
   logic [ptld_pkg::NUM_W-1:0]    pp_wide;

   // final stage
   logic [ptld_pkg::SQ_W-1:0]     mag_ff;
   logic [ptld_pkg::NUM_W-1:0]    num_ff;
   logic [ptld_pkg::PP_IDX_W-1:0] idx_ff;
   logic [ptld_pkg::DIST_W-1:0]   dist_ff;
   logic                          degen_ff;

   logic [ptld_pkg::SQ_W-1:0]     x_op;
   logic [ptld_pkg::SQ_W-1:0]     y_op;
   logic [ptld_pkg::VD_W-1:0]     vd_abs;

   logic [ptld_pkg::DIFF_W-1:0]   v_diff;
   logic [ptld_pkg::DIFF_W-1:0]   d_diff;
   logic                          accept;
   logic                          take;
   logic                          out_load;
   logic                          ds_start;
   logic                          ds_done;
   logic [ptld_pkg::DIST_W-1:0]   ds_root;

   logic                          rsp_valid_ff;
   logic [ptld_pkg::DIST_W-1:0]   rsp_distance_ff;
   logic                          rsp_degenerate_ff;
   logic                          rsp_too_many_ff;

   assign accept  = req_valid && (state_ff == ptld_pkg::ST_IDLE);
   assign take    = (cnt_ff < CNT_W'(MAX_DIMS));
   assign v_diff  = {req_point_coord[ptld_pkg::COORD_W-1], req_point_coord}
                  - {req_line_start_coord[ptld_pkg::COORD_W-1], req_line_start_coord};
   assign d_diff  = {req_line_end_coord[ptld_pkg::COORD_W-1], req_line_end_coord}
                  - {req_line_start_coord[ptld_pkg::COORD_W-1], req_line_start_coord};
   assign prod_in = {{ptld_pkg::MUL_W{1'b0}}, mul_a} * {{ptld_pkg::MUL_W{1'b0}}, mul_b};
   assign vd_abs  = vd_ff[ptld_pkg::VD_W-1] ? (~vd_ff + 1'b1) : vd_ff;
   assign x_op    = idx_ff[2] ? mag_ff : vv_ff;
   assign y_op    = idx_ff[2] ? mag_ff : dd_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_distance        = rsp_distance_ff;
   assign rsp_degenerate_line = rsp_degenerate_ff;
   assign rsp_too_many_coords = rsp_too_many_ff;

   always_comb begin
      unique case (pp_shift_ff)
         2'd0:    pp_wide = {{(ptld_pkg::NUM_W - ptld_pkg::PROD_W){1'b0}}, prod_ff};
         2'd1:    pp_wide = {{(ptld_pkg::NUM_W - ptld_pkg::PROD_W - ptld_pkg::MUL_W){1'b0}},
                             prod_ff, {ptld_pkg::MUL_W{1'b0}}};
         2'd2:    pp_wide = {prod_ff, {(ptld_pkg::NUM_W - ptld_pkg::PROD_W){1'b0}}};
         default: pp_wide = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptld_pkg::ST_IDLE:      if (req_valid) state_in = ptld_pkg::ST_MUL_VD;
         ptld_pkg::ST_MUL_VD:    state_in = ptld_pkg::ST_MUL_DD;
         ptld_pkg::ST_MUL_DD:    state_in = ptld_pkg::ST_MUL_VV;
         ptld_pkg::ST_MUL_VV:    state_in = ptld_pkg::ST_ACC_VV;
         ptld_pkg::ST_ACC_VV:    state_in = last_ff ? ptld_pkg::ST_CHECK : ptld_pkg::ST_IDLE;
         ptld_pkg::ST_CHECK:
            state_in = (dd_ff == '0) ? ptld_pkg::ST_OUT : ptld_pkg::ST_NUM_MUL;
         ptld_pkg::ST_NUM_MUL:
            if (idx_ff == ptld_pkg::PP_IDX_W'(ptld_pkg::PP_COUNT - 1))
               state_in = ptld_pkg::ST_NUM_ACC;
         ptld_pkg::ST_NUM_ACC:   state_in = ptld_pkg::ST_ROOT_GO;
         ptld_pkg::ST_ROOT_GO:   state_in = ptld_pkg::ST_ROOT_WAIT;
         ptld_pkg::ST_ROOT_WAIT: if (ds_done) state_in = ptld_pkg::ST_OUT;
         ptld_pkg::ST_OUT:       if (out_load) state_in = ptld_pkg::ST_IDLE;
         default:                state_in = ptld_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall   = (state_ff != ptld_pkg::ST_IDLE);
      ds_start    = (state_ff == ptld_pkg::ST_ROOT_GO);
      out_load    = (state_ff == ptld_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);
      mul_a       = '0;
      mul_b       = '0;
      pp_op_in    = ptld_pkg::PP_NONE;
      pp_shift_in = 2'd0;
      unique case (state_ff)
         ptld_pkg::ST_MUL_VD: begin
            mul_a = ptld_pkg::MUL_W'(v_mag_ff);
            mul_b = ptld_pkg::MUL_W'(d_mag_ff);
            if (take_ff) pp_op_in = vd_neg_ff ? ptld_pkg::PP_VD_NEG : ptld_pkg::PP_VD_POS;
         end
         ptld_pkg::ST_MUL_DD: begin
            mul_a = ptld_pkg::MUL_W'(d_mag_ff);
            mul_b = ptld_pkg::MUL_W'(d_mag_ff);
            if (take_ff) pp_op_in = ptld_pkg::PP_DD;
         end
         ptld_pkg::ST_MUL_VV: begin
            mul_a = ptld_pkg::MUL_W'(v_mag_ff);
            mul_b = ptld_pkg::MUL_W'(v_mag_ff);
            if (take_ff) pp_op_in = ptld_pkg::PP_VV;
         end
         ptld_pkg::ST_NUM_MUL: begin
            mul_a = idx_ff[1] ? ptld_pkg::MUL_W'(x_op[ptld_pkg::SQ_W-1:ptld_pkg::MUL_W])
                              : x_op[ptld_pkg::MUL_W-1:0];
            mul_b = idx_ff[0] ? ptld_pkg::MUL_W'(y_op[ptld_pkg::SQ_W-1:ptld_pkg::MUL_W])
                              : y_op[ptld_pkg::MUL_W-1:0];
            pp_op_in    = idx_ff[2] ? ptld_pkg::PP_NUM_SUB : ptld_pkg::PP_NUM_ADD;
            pp_shift_in = 2'({1'b0, idx_ff[1]} + {1'b0, idx_ff[0]});
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptld_pkg::ST_IDLE;
         pp_op_ff     <= ptld_pkg::PP_NONE;
         rsp_valid_ff <= 1'b0;
         vd_ff        <= '0;
         dd_ff        <= '0;
         vv_ff        <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         pp_op_ff <= pp_op_in;

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (accept) begin
            if (take) cnt_ff <= cnt_ff + 1'b1;
            else      ovf_ff <= 1'b1;
         end

         unique case (pp_op_ff)
            ptld_pkg::PP_VD_POS: vd_ff <= vd_ff + prod_ff;
            ptld_pkg::PP_VD_NEG: vd_ff <= vd_ff - prod_ff;
            ptld_pkg::PP_DD:     dd_ff <= dd_ff + prod_ff[ptld_pkg::SQ_W-1:0];
            ptld_pkg::PP_VV:     vv_ff <= vv_ff + prod_ff[ptld_pkg::SQ_W-1:0];
            default: begin
            end
         endcase

         if (state_ff == ptld_pkg::ST_CHECK) idx_ff <= '0;
         else if (state_ff == ptld_pkg::ST_NUM_MUL) idx_ff <= idx_ff + 1'b1;

         if (out_load) begin
            vd_ff  <= '0;
            dd_ff  <= '0;
            vv_ff  <= '0;
            cnt_ff <= '0;
            ovf_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      pp_shift_ff <= pp_shift_in;

      if (accept) begin
         v_mag_ff  <= v_diff[ptld_pkg::DIFF_W-1] ? -v_diff : v_diff;
         d_mag_ff  <= d_diff[ptld_pkg::DIFF_W-1] ? -d_diff : d_diff;
         vd_neg_ff <= v_diff[ptld_pkg::DIFF_W-1] ^ d_diff[ptld_pkg::DIFF_W-1];
         last_ff   <= req_last_coord;
         take_ff   <= take;
      end

      if (state_ff == ptld_pkg::ST_CHECK) begin
         mag_ff   <= vd_abs[ptld_pkg::SQ_W-1:0];
         num_ff   <= '0;
         dist_ff  <= '0;
         degen_ff <= (dd_ff == '0);
      end else if (pp_op_ff == ptld_pkg::PP_NUM_ADD) begin
         num_ff <= num_ff + pp_wide;
      end else if (pp_op_ff == ptld_pkg::PP_NUM_SUB) begin
         num_ff <= num_ff - pp_wide;
      end

      if ((state_ff == ptld_pkg::ST_ROOT_WAIT) && ds_done) dist_ff <= ds_root;

      if (out_load) begin
         rsp_distance_ff   <= dist_ff;
         rsp_degenerate_ff <= degen_ff;
         rsp_too_many_ff   <= ovf_ff;
      end
   end

   ptld_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .start (ds_start),
      .num   (num_ff[ptld_pkg::QNUM_W-1:0]),
      .den   (dd_ff),
      .done  (ds_done),
      .root  (ds_root)
   );

endmodule

### verif/tb.sv
// Testbench for point_to_line_distance: streams coordinate transactions and checks each
// distance response against a bit-exact scoreboard prediction. Depends on ptld_pkg and the RTL.

typedef struct {
   logic [ptld_pkg::DIST_W-1:0] distance;
   logic                        degenerate_line;
   logic                        too_many_coords;
} dist_result_type;

class distance_scoreboard;
   logic signed [ptld_pkg::VD_W-1:0] sum_vd;
   logic [ptld_pkg::SQ_W-1:0]        sum_dd;
   logic [ptld_pkg::SQ_W-1:0]        sum_vv;
   int unsigned                      axis_count;
   bit                               overflow;
   dist_result_type                  expected_q[$];
   int unsigned                      fail_count;

   function new();
      clear_sums();
      fail_count = 0;
   endfunction

   function void clear_sums();
      sum_vd = '0;
      sum_dd = '0;
      sum_vv = '0;
      axis_count = 0;
      overflow = 1'b0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   static function logic [31:0] int_root(input logic [63:0] x);
      logic [63:0] trial;
      logic [31:0] root;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = {32'd0, root | (32'd1 << i)};
         if (trial * trial <= x)
            root = root | (32'd1 << i);
      end
      return root;
   endfunction

   function void note_coord(input logic signed [ptld_pkg::COORD_W-1:0] p, a, b,
                            input logic is_last);
      logic signed [ptld_pkg::DIFF_W-1:0] d, v;
      logic signed [63:0]                 dl, vl, vd64;
      logic [127:0]                       w_vv, w_dd, w_m, num, quo;
      logic [31:0]                        root;
      dist_result_type                    res;
      if (axis_count < ptld_pkg::MAX_DIMS_DEF) begin
         d = b - a;
         v = p - a;
         dl = 64'(d);
         vl = 64'(v);
         sum_vd = ptld_pkg::VD_W'(sum_vd + vl * dl);
         sum_dd = ptld_pkg::SQ_W'(sum_dd + dl * dl);
         sum_vv = ptld_pkg::SQ_W'(sum_vv + vl * vl);
         axis_count++;
      end else begin
         overflow = 1'b1;
      end
      if (!is_last)
         return;
      res.distance = '0;
      res.degenerate_line = 1'b0;
      res.too_many_coords = overflow;
      if (sum_dd == '0) begin
         res.degenerate_line = 1'b1;
      end else begin
         vd64 = 64'(sum_vd);
         w_m = (vd64 < 0) ? 128'(-vd64) : 128'(vd64);
         w_vv = 128'(sum_vv);
         w_dd = 128'(sum_dd);
         num = w_vv * w_dd - w_m * w_m;
         quo = num / w_dd;
         root = int_root(quo[63:0]);
         res.distance = root[ptld_pkg::DIST_W-1:0];
      end
      expected_q.push_back(res);
      clear_sums();
   endfunction

   function void check_result(input logic [ptld_pkg::DIST_W-1:0] distance,
                              input logic degenerate_line, input logic too_many_coords);
      dist_result_type exp_res;
      if (expected_q.size() == 0) begin
         $error("unexpected response: distance=%0d degenerate_line=%0b too_many_coords=%0b",
                distance, degenerate_line, too_many_coords);
         fail_count++;
         return;
      end
      exp_res = expected_q.pop_front();
      if (distance !== exp_res.distance) begin
         $error("distance: expected %0d, actual %0d", exp_res.distance, distance);
         fail_count++;
      end
      if (degenerate_line !== exp_res.degenerate_line) begin
         $error("degenerate_line: expected %0b, actual %0b", exp_res.degenerate_line,
                degenerate_line);
         fail_count++;
      end
      if (too_many_coords !== exp_res.too_many_coords) begin
         $error("too_many_coords: expected %0b, actual %0b", exp_res.too_many_coords,
                too_many_coords);
         fail_count++;
      end
   endfunction
endclass

module tb;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned NUM_ITEMS   = 1700;
   localparam int unsigned DRAIN_CYCLES = 120;
   localparam logic signed [ptld_pkg::COORD_W-1:0] COORD_MAX =
      {1'b0, {(ptld_pkg::COORD_W-1){1'b1}}};
   localparam logic signed [ptld_pkg::COORD_W-1:0] COORD_MIN =
      {1'b1, {(ptld_pkg::COORD_W-1){1'b0}}};

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [ptld_pkg::COORD_W-1:0] req_point_coord = '0;
   logic signed [ptld_pkg::COORD_W-1:0] req_line_start_coord = '0;
   logic signed [ptld_pkg::COORD_W-1:0] req_line_end_coord = '0;
   logic                                req_last_coord = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [ptld_pkg::DIST_W-1:0]         rsp_distance;
   logic                                rsp_degenerate_line;
   logic                                rsp_too_many_coords;

   distance_scoreboard sb;
   int unsigned        items_sent = 0;
   int unsigned        cycle_count = 0;
   int unsigned        stall_left = 0;
   bit                 req_quiet = 1'b0;
   bit                 rsp_quiet = 1'b0;

   point_to_line_distance dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_point_coord     (req_point_coord),
      .req_line_start_coord(req_line_start_coord),
      .req_line_end_coord  (req_line_end_coord),
      .req_last_coord      (req_last_coord),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_distance        (rsp_distance),
      .rsp_degenerate_line (rsp_degenerate_line),
      .rsp_too_many_coords (rsp_too_many_coords)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transaction monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_distance, rsp_degenerate_line, rsp_too_many_coords);
         if (req_valid && !req_stall)
            sb.note_coord(req_point_coord, req_line_start_coord, req_line_end_coord,
                          req_last_coord);
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0)
         rsp_quiet = !rsp_quiet;
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!rsp_quiet && $urandom_range(0, 3) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                  : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (req_quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [ptld_pkg::COORD_W-1:0] rand_coord(input bit tiny);
      if (tiny)
         return ptld_pkg::COORD_W'($urandom_range(0, 16383) - 8192);
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3: return ptld_pkg::COORD_W'($urandom_range(0, 16383) - 8192);
         default: return ptld_pkg::COORD_W'($urandom);
      endcase
   endfunction

   task automatic send_coord(input logic signed [ptld_pkg::COORD_W-1:0] p, a, b,
                             input logic is_last);
      int unsigned gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_point_coord <= p;
      req_line_start_coord <= a;
      req_line_end_coord <= b;
      req_last_coord <= is_last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_point_coord <= ptld_pkg::COORD_W'($urandom);
         req_line_start_coord <= ptld_pkg::COORD_W'($urandom);
         req_line_end_coord <= ptld_pkg::COORD_W'($urandom);
         req_last_coord <= 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // one point triple; kind: general, coincident line ends, point on an end, small values
   task automatic send_point();
      int unsigned dims, kind, r;
      bit          on_end;
      logic signed [ptld_pkg::COORD_W-1:0] p, a, b;
      r = $urandom_range(0, 99);
      if (r < 75)
         dims = $urandom_range(1, ptld_pkg::MAX_DIMS_DEF);
      else if (r < 90)
         dims = ptld_pkg::MAX_DIMS_DEF;
      else
         dims = $urandom_range(ptld_pkg::MAX_DIMS_DEF + 1, ptld_pkg::MAX_DIMS_DEF + 4);
      kind = $urandom_range(0, 9);
      on_end = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0)
         req_quiet = !req_quiet;
      for (int unsigned i = 0; i < dims; i++) begin
         a = rand_coord(kind >= 8);
         b = (kind == 5) ? a : rand_coord(kind >= 8);
         if (kind == 6 || kind == 7)
            p = on_end ? b : a;
         else
            p = rand_coord(kind >= 8);
         send_coord(p, a, b, i == dims - 1);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, coincident ends, zero triple, too many axes
      send_coord(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      send_coord(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
      send_coord('0, COORD_MIN, COORD_MAX, 1'b0);
      send_coord(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
      send_coord(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
      send_coord(COORD_MAX, '0, '0, 1'b1);
      send_coord('0, '0, '0, 1'b1);
      for (int unsigned i = 0; i <= ptld_pkg::MAX_DIMS_DEF; i++)
         send_coord(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                    i == ptld_pkg::MAX_DIMS_DEF);

      while (items_sent < NUM_ITEMS)
         send_point();

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
